/* rtl/kffc_pkg.sv */
// Shared types, key codes and constants for the keypad four-function calculator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package kffc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OUT_WIDTH = 32;

	// ASCII key codes that the calculator reacts to.
	localparam logic [7:0] KEY_0   = 8'h30;
	localparam logic [7:0] KEY_9   = 8'h39;
	localparam logic [7:0] KEY_ADD = 8'h2B;
	localparam logic [7:0] KEY_SUB = 8'h2D;
	localparam logic [7:0] KEY_MUL = 8'h2A;
	localparam logic [7:0] KEY_DIV = 8'h2F;
	localparam logic [7:0] KEY_EQ  = 8'h3D;
	localparam logic [7:0] KEY_CLR = 8'h43;

	// Entry is decimal; the operand times ten is built as (x << 3) + (x << 1).
	localparam int DIGIT_BASE = 10;
	localparam int DIGIT_SHIFT_HI = 3;
	localparam int DIGIT_SHIFT_LO = 1;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		EV_IGNORED = 3'd0,
		EV_DIGIT   = 3'd1,
		EV_OPER    = 3'd2,
		EV_RESULT  = 3'd3,
		EV_DIV0    = 3'd4,
		EV_CLEAR   = 3'd5
	} kind_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WAIT,
		ST_FINISH
	} state_t;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		MD_ADD,
		MD_SUB,
		MD_MUL,
		MD_DIV
	} md_op_t;

	// Phases of the shared arithmetic unit.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ONE,
		PH_ABS_A,
		PH_ABS_B,
		PH_ITER,
		PH_SIGN,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_cmd_t;

	typedef struct packed {
		logic done;
	} md_sts_t;

endpackage

/* rtl/kffc_mdu.sv */
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
// All work goes through one adder/subtractor. Depends on kffc_pkg.
module kffc_mdu #(
	parameter int VALUE_WIDTH = kffc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kffc_pkg::md_cmd_t       cmd,
	input  logic [VALUE_WIDTH-1:0]  opa,
	input  logic [VALUE_WIDTH-1:0]  opb,
	output kffc_pkg::md_sts_t       sts,
	output logic [VALUE_WIDTH-1:0]  result
);

	localparam int VW = VALUE_WIDTH;
	localparam int AW = VW + 2;
	localparam int CW = $clog2(VW);

	kffc_pkg::phase_t phase_q, phase_d;
	kffc_pkg::md_op_t op_q;
	logic [VW:0]      acc_q;
	logic [VW-1:0]    x_q;
	logic [VW-1:0]    y_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;

	logic [AW-1:0] add_a;
	logic [AW-1:0] add_b;
	logic          add_sub;
	logic [AW-1:0] sum;
	logic [VW:0]   rem_shift;

	assign rem_shift = {acc_q[VW-1:0], x_q[VW-1]};

	// Operand selection for the single adder.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (phase_q)
			kffc_pkg::PH_ONE: begin
				add_a   = AW'(x_q);
				add_b   = AW'(y_q);
				add_sub = (op_q == kffc_pkg::MD_SUB);
			end
			kffc_pkg::PH_ABS_A: begin
				add_b   = AW'(x_q);
				add_sub = 1'b1;
			end
			kffc_pkg::PH_ABS_B: begin
				add_b   = AW'(y_q);
				add_sub = 1'b1;
			end
			kffc_pkg::PH_ITER: begin
				if (op_q == kffc_pkg::MD_DIV) begin
					add_a   = AW'(rem_shift);
					add_b   = AW'(y_q);
					add_sub = 1'b1;
				end else begin
					add_a = AW'(acc_q);
					add_b = y_q[0] ? AW'(x_q) : '0;
				end
			end
			kffc_pkg::PH_SIGN: begin
				add_b   = AW'(x_q);
				add_sub = 1'b1;
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			kffc_pkg::PH_IDLE: begin
				if (cmd.start) begin
					case (cmd.op)
						kffc_pkg::MD_DIV: phase_d = kffc_pkg::PH_ABS_A;
						kffc_pkg::MD_MUL: phase_d = kffc_pkg::PH_ITER;
						default:          phase_d = kffc_pkg::PH_ONE;
					endcase
				end
			end
			kffc_pkg::PH_ONE:   phase_d = kffc_pkg::PH_DONE;
			kffc_pkg::PH_ABS_A: phase_d = kffc_pkg::PH_ABS_B;
			kffc_pkg::PH_ABS_B: phase_d = kffc_pkg::PH_ITER;
			kffc_pkg::PH_ITER: begin
				if (cnt_q == '0) begin
					phase_d = (op_q == kffc_pkg::MD_DIV) ? kffc_pkg::PH_SIGN
						: kffc_pkg::PH_DONE;
				end
			end
			kffc_pkg::PH_SIGN:  phase_d = kffc_pkg::PH_DONE;
			kffc_pkg::PH_DONE:  phase_d = kffc_pkg::PH_IDLE;
			default:            phase_d = kffc_pkg::PH_IDLE;
		endcase
	end

	// Status outputs.
	always_comb begin
		sts.done = (phase_q == kffc_pkg::PH_DONE);
		result   = (op_q == kffc_pkg::MD_DIV) ? x_q : acc_q[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kffc_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q == kffc_pkg::PH_IDLE) begin
				cnt_q <= CW'(VW - 1);
			end else if (phase_q == kffc_pkg::PH_ITER) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (phase_q)
			kffc_pkg::PH_IDLE: begin
				if (cmd.start) begin
					x_q   <= opa;
					y_q   <= opb;
					acc_q <= '0;
					op_q  <= cmd.op;
					neg_q <= opa[VW-1] ^ opb[VW-1];
				end
			end
			kffc_pkg::PH_ONE: begin
				acc_q <= {1'b0, sum[VW-1:0]};
			end
			kffc_pkg::PH_ABS_A: begin
				if (x_q[VW-1]) begin
					x_q <= sum[VW-1:0];
				end
			end
			kffc_pkg::PH_ABS_B: begin
				if (y_q[VW-1]) begin
					y_q <= sum[VW-1:0];
				end
			end
			kffc_pkg::PH_ITER: begin
				if (op_q == kffc_pkg::MD_DIV) begin
					// Restoring step: keep the difference when it did not go negative.
					acc_q <= sum[AW-1] ? rem_shift : sum[VW:0];
					x_q   <= {x_q[VW-2:0], ~sum[AW-1]};
				end else begin
					acc_q <= {1'b0, sum[VW-1:0]};
					x_q   <= x_q << 1;
					y_q   <= y_q >> 1;
				end
			end
			kffc_pkg::PH_SIGN: begin
				if (neg_q) begin
					x_q <= sum[VW-1:0];
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

/* rtl/keypad_four_function_calculator_unit.sv */
// Top level of the keypad four-function calculator: key decode, operand state,
// sequencer and output register. Depends on kffc_pkg and kffc_mdu.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------------
//   input   | in_valid / in_ready  | key_code
//   output  | out_valid / out_ready| event_kind, first_value, second_value,
//           |                      | pending_op, result_value, entering_second
//
// Every key gives exactly one result transfer. Digits, operators, 'C', ignored keys,
// '=' with no operation and divide by zero go from DECODE straight to FINISH, where the
// result is registered, and the next key can transfer once the sequencer is idle again.
// '=' with add, subtract, multiply or divide waits in WAIT until the shared unit is done;
// the shared unit runs its multiply and divide loop at one bit per cycle.
// Reset is asynchronous and clears the operands, the operation and the sequencer.
// in_ready is high only while the sequencer is idle. A result waiting in the output
// register does not block the next key; only the final write of the following key
// waits until the output register has been emptied.
module keypad_four_function_calculator_unit #(
	parameter int VALUE_WIDTH = kffc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            key_code,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0]                            event_kind,
	output logic signed [kffc_pkg::OUT_WIDTH-1:0] first_value,
	output logic signed [kffc_pkg::OUT_WIDTH-1:0] second_value,
	output logic [2:0]                            pending_op,
	output logic signed [kffc_pkg::OUT_WIDTH-1:0] result_value,
	output logic                                  entering_second
);

	localparam int VW = VALUE_WIDTH;
	localparam int OW = kffc_pkg::OUT_WIDTH;

	kffc_pkg::state_t state_q, state_d;

	// Architectural state.
	logic [VW-1:0]    first_q;
	logic [VW-1:0]    second_q;
	kffc_pkg::op_t    op_q;
	logic             active2_q;

	// Key being worked on and its classification.
	logic [7:0]       key_q;
	kffc_pkg::kind_t  kind_q;
	kffc_pkg::kind_t  kind_d;

	// Output register.
	logic             out_valid_q;
	kffc_pkg::kind_t  event_kind_q;
	logic [OW-1:0]    first_value_q;
	logic [OW-1:0]    second_value_q;
	kffc_pkg::op_t    pending_op_q;
	logic [OW-1:0]    result_value_q;
	logic             entering_second_q;

	// Shared unit.
	kffc_pkg::md_cmd_t md_cmd;
	kffc_pkg::md_sts_t md_sts;
	logic [VW-1:0]     md_result;

	// Sequencer strobes.
	logic             accept_in;
	logic             commit;
	logic             out_free;

	// Next values of the state, formed when the key commits.
	logic [VW-1:0]    first_n;
	logic [VW-1:0]    second_n;
	kffc_pkg::op_t    op_n;
	logic             active2_n;
	logic [VW-1:0]    res_n;
	logic [VW-1:0]    entry_val;
	logic [VW-1:0]    entry_next;
	logic [VW-1:0]    digit_val;
	logic             is_digit;
	logic             is_oper;
	logic             needs_unit;

	assign is_digit = (key_q >= kffc_pkg::KEY_0) && (key_q <= kffc_pkg::KEY_9);
	assign is_oper  = (key_q == kffc_pkg::KEY_ADD) || (key_q == kffc_pkg::KEY_SUB)
		|| (key_q == kffc_pkg::KEY_MUL) || (key_q == kffc_pkg::KEY_DIV);

	// Classify the key against the current state.
	always_comb begin
		kind_d = kffc_pkg::EV_IGNORED;
		if (is_digit) begin
			kind_d = kffc_pkg::EV_DIGIT;
		end else if (is_oper) begin
			kind_d = kffc_pkg::EV_OPER;
		end else if (key_q == kffc_pkg::KEY_EQ) begin
			if ((op_q == kffc_pkg::OP_DIV) && (second_q == '0)) begin
				kind_d = kffc_pkg::EV_DIV0;
			end else begin
				kind_d = kffc_pkg::EV_RESULT;
			end
		end else if (key_q == kffc_pkg::KEY_CLR) begin
			kind_d = kffc_pkg::EV_CLEAR;
		end
	end

	// '=' with a real operation, other than divide by zero, goes through the shared unit.
	assign needs_unit = (kind_d == kffc_pkg::EV_RESULT) && (op_q != kffc_pkg::OP_NONE);

	assign out_free  = !out_valid_q || out_ready;
	assign accept_in = in_valid && in_ready;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			kffc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = kffc_pkg::ST_DECODE;
				end
			end
			kffc_pkg::ST_DECODE: begin
				state_d = needs_unit ? kffc_pkg::ST_WAIT : kffc_pkg::ST_FINISH;
			end
			kffc_pkg::ST_WAIT: begin
				if (md_sts.done) begin
					state_d = kffc_pkg::ST_FINISH;
				end
			end
			kffc_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = kffc_pkg::ST_IDLE;
				end
			end
			default: state_d = kffc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready     = (state_q == kffc_pkg::ST_IDLE);
		commit       = (state_q == kffc_pkg::ST_FINISH) && out_free;
		md_cmd.start = (state_q == kffc_pkg::ST_DECODE) && needs_unit;
		case (op_q)
			kffc_pkg::OP_SUB: md_cmd.op = kffc_pkg::MD_SUB;
			kffc_pkg::OP_MUL: md_cmd.op = kffc_pkg::MD_MUL;
			kffc_pkg::OP_DIV: md_cmd.op = kffc_pkg::MD_DIV;
			default:          md_cmd.op = kffc_pkg::MD_ADD;
		endcase
	end

	kffc_mdu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd),
		.opa    (first_q),
		.opb    (second_q),
		.sts    (md_sts),
		.result (md_result)
	);

	// Decimal entry: operand times ten plus the digit, wrapping at the value width.
	assign entry_val  = active2_q ? second_q : first_q;
	assign digit_val  = VW'(key_q[3:0]);
	assign entry_next = (entry_val << kffc_pkg::DIGIT_SHIFT_HI)
		+ (entry_val << kffc_pkg::DIGIT_SHIFT_LO) + digit_val;

	// State after the key.
	always_comb begin
		first_n   = first_q;
		second_n  = second_q;
		op_n      = op_q;
		active2_n = active2_q;
		res_n     = (op_q == kffc_pkg::OP_NONE) ? first_q : md_result;
		case (kind_q)
			kffc_pkg::EV_DIGIT: begin
				if (active2_q) begin
					second_n = entry_next;
				end else begin
					first_n = entry_next;
				end
			end
			kffc_pkg::EV_OPER: begin
				active2_n = 1'b1;
				case (key_q)
					kffc_pkg::KEY_ADD: op_n = kffc_pkg::OP_ADD;
					kffc_pkg::KEY_SUB: op_n = kffc_pkg::OP_SUB;
					kffc_pkg::KEY_MUL: op_n = kffc_pkg::OP_MUL;
					default:           op_n = kffc_pkg::OP_DIV;
				endcase
			end
			kffc_pkg::EV_RESULT: begin
				first_n   = res_n;
				second_n  = '0;
				op_n      = kffc_pkg::OP_NONE;
				active2_n = 1'b0;
			end
			kffc_pkg::EV_DIV0: begin
				active2_n = 1'b0;
			end
			kffc_pkg::EV_CLEAR: begin
				first_n   = '0;
				second_n  = '0;
				op_n      = kffc_pkg::OP_NONE;
				active2_n = 1'b0;
			end
			default: begin
				first_n = first_q;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kffc_pkg::ST_IDLE;
			first_q     <= '0;
			second_q    <= '0;
			op_q        <= kffc_pkg::OP_NONE;
			active2_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				first_q     <= first_n;
				second_q    <= second_n;
				op_q        <= op_n;
				active2_q   <= active2_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			key_q <= key_code;
		end
		if (state_q == kffc_pkg::ST_DECODE) begin
			kind_q <= kind_d;
		end
		if (commit) begin
			event_kind_q      <= kind_q;
			first_value_q     <= OW'(signed'(first_n));
			second_value_q    <= OW'(signed'(second_n));
			pending_op_q      <= op_n;
			entering_second_q <= active2_n;
			result_value_q    <= (kind_q == kffc_pkg::EV_RESULT) ? OW'(signed'(res_n)) : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_kind      = event_kind_q;
	assign first_value     = first_value_q;
	assign second_value    = second_value_q;
	assign pending_op      = pending_op_q;
	assign result_value    = result_value_q;
	assign entering_second = entering_second_q;

endmodule

/* rtl/kffc_checker.sv */
// Port-level checker for the keypad four-function calculator and its bind statement.
// Depends on kffc_pkg and on the top level keypad_four_function_calculator_unit.
module kffc_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic [2:0]                            event_kind,
	input logic signed [kffc_pkg::OUT_WIDTH-1:0] first_value,
	input logic signed [kffc_pkg::OUT_WIDTH-1:0] second_value,
	input logic [2:0]                            pending_op,
	input logic signed [kffc_pkg::OUT_WIDTH-1:0] result_value,
	input logic                                  entering_second
);

	// A key transfer keeps the block busy for at least the next cycle.
	a_busy_after_key: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after a key transfer");

	a_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind != kffc_pkg::EV_RESULT) |-> (result_value == '0))
		else $error("result_value nonzero outside a result event");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == kffc_pkg::EV_CLEAR) |->
		(first_value == '0) && (second_value == '0)
		&& (pending_op == kffc_pkg::OP_NONE) && !entering_second)
		else $error("clear event did not show a cleared state");

	a_eq_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((event_kind == kffc_pkg::EV_RESULT)
		|| (event_kind == kffc_pkg::EV_DIV0)) |-> !entering_second)
		else $error("entry did not return to the first operand after equals");

	a_oper_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == kffc_pkg::EV_OPER) |->
		entering_second && (pending_op != kffc_pkg::OP_NONE))
		else $error("operator event without a pending operation");

endmodule

bind keypad_four_function_calculator_unit kffc_checker u_kffc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.event_kind      (event_kind),
	.first_value     (first_value),
	.second_value    (second_value),
	.pending_op      (pending_op),
	.result_value    (result_value),
	.entering_second (entering_second)
);

/* tb/sv/kffc_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the keypad four-function calculator. It watches both channels,
// predicts the result transfer of every accepted key and compares it field by field.
// Depends on kffc_pkg for the key codes and the operation and event enums.
module kffc_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  key_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  event_kind,
	input  logic [31:0] first_value,
	input  logic [31:0] second_value,
	input  logic [2:0]  pending_op,
	input  logic [31:0] result_value,
	input  logic        entering_second,
	output int          mismatch_count,
	output int          keys_in_flight
);
	import kffc_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [31:0] first;
		logic [31:0] second;
		op_t         op;
		logic [31:0] result;
		logic        second_active;
	} key_event_t;

	// Calculator state as the checker believes it to be.
	logic [31:0] calc_first;
	logic [31:0] calc_second;
	op_t         calc_op;
	logic        calc_entering_second;

	key_event_t  expected_key_events[$];
	key_event_t  oldest;
	int          errors;

	// Truncating signed quotient; the most negative value over minus one wraps.
	function automatic logic [31:0] signed_quotient(logic [31:0] num, logic [31:0] den);
		logic [31:0] mag_num;
		logic [31:0] mag_den;
		logic [31:0] quot;
		mag_num = num[31] ? -num : num;
		mag_den = den[31] ? -den : den;
		quot = mag_num / mag_den;
		return (num[31] ^ den[31]) ? -quot : quot;
	endfunction

	function automatic key_event_t press_key(logic [7:0] key);
		key_event_t  ev;
		logic [31:0] value;
		logic [31:0] digit;
		logic        ok;
		ev.kind = EV_IGNORED;
		value = '0;
		digit = {24'd0, key - KEY_0};
		ok = 1'b1;
		if (key >= KEY_0 && key <= KEY_9) begin
			if (calc_entering_second)
				calc_second = calc_second * 32'd10 + digit;
			else
				calc_first = calc_first * 32'd10 + digit;
			ev.kind = EV_DIGIT;
		end else if (key == KEY_ADD || key == KEY_SUB || key == KEY_MUL || key == KEY_DIV) begin
			case (key)
				KEY_ADD: calc_op = OP_ADD;
				KEY_SUB: calc_op = OP_SUB;
				KEY_MUL: calc_op = OP_MUL;
				default: calc_op = OP_DIV;
			endcase
			calc_entering_second = 1'b1;
			ev.kind = EV_OPER;
		end else if (key == KEY_EQ) begin
			case (calc_op)
				OP_ADD: value = calc_first + calc_second;
				OP_SUB: value = calc_first - calc_second;
				OP_MUL: value = calc_first * calc_second;
				OP_DIV: begin
					if (calc_second == '0)
						ok = 1'b0;
					else
						value = signed_quotient(calc_first, calc_second);
				end
				default: value = calc_first;
			endcase
			if (ok) begin
				calc_first = value;
				calc_second = '0;
				calc_op = OP_NONE;
				ev.kind = EV_RESULT;
			end else begin
				ev.kind = EV_DIV0;
			end
			calc_entering_second = 1'b0;
		end else if (key == KEY_CLR) begin
			calc_first = '0;
			calc_second = '0;
			calc_op = OP_NONE;
			calc_entering_second = 1'b0;
			ev.kind = EV_CLEAR;
		end
		ev.first = calc_first;
		ev.second = calc_second;
		ev.op = calc_op;
		ev.result = (ev.kind == EV_RESULT) ? value : '0;
		ev.second_active = calc_entering_second;
		return ev;
	endfunction

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s differs: expected %h, actual %h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_first = '0;
			calc_second = '0;
			calc_op = OP_NONE;
			calc_entering_second = 1'b0;
			expected_key_events.delete();
			errors = 0;
		end else begin
			// A result cannot leave in the cycle its own key enters, so check first.
			if (out_valid && out_ready) begin
				if (expected_key_events.size() == 0) begin
					$display("%0t: unexpected result transfer: expected none, actual kind %h",
						$time, event_kind);
					errors++;
				end else begin
					oldest = expected_key_events.pop_front();
					errors += field_differs("event_kind", oldest.kind, event_kind);
					errors += field_differs("first_value", oldest.first, first_value);
					errors += field_differs("second_value", oldest.second, second_value);
					errors += field_differs("pending_op", oldest.op, pending_op);
					errors += field_differs("result_value", oldest.result, result_value);
					errors += field_differs("entering_second", oldest.second_active,
						entering_second);
				end
			end
			if (in_valid && in_ready)
				expected_key_events.push_back(press_key(key_code));
		end
		mismatch_count <= errors;
		keys_in_flight <= expected_key_events.size();
	end

endmodule

/* tb/sv/tb_keypad_four_function_calculator_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the keypad four-function calculator: drives key transfers and the
// result receiver, and gives the verdict. Depends on kffc_pkg, the calculator RTL and
// kffc_result_checker, which predicts and compares every result transfer.
module tb_keypad_four_function_calculator_unit;
	import kffc_pkg::*;

	// Roughly how many meaningful keys the whole run offers.
	localparam int KEY_TARGET = 1850;
	// The receiver's long hold-off: when it starts, in cycles after reset, and how long.
	localparam int HOLD_START = 3000;
	localparam int HOLD_CYCLES = 500;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         key_code;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         event_kind;
	logic signed [31:0] first_value;
	logic signed [31:0] second_value;
	logic [2:0]         pending_op;
	logic signed [31:0] result_value;
	logic               entering_second;

	int mismatch_count;
	int keys_in_flight;
	int keys_sent;
	int burst_left;

	keypad_four_function_calculator_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_code        (key_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_kind      (event_kind),
		.first_value     (first_value),
		.second_value    (second_value),
		.pending_op      (pending_op),
		.result_value    (result_value),
		.entering_second (entering_second)
	);

	kffc_result_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_code        (key_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_kind      (event_kind),
		.first_value     (first_value),
		.second_value    (second_value),
		.pending_op      (pending_op),
		.result_value    (result_value),
		.entering_second (entering_second),
		.mismatch_count  (mismatch_count),
		.keys_in_flight  (keys_in_flight)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The sender works in bursts. Within a burst valid stays high and the next key
	// replaces the payload right after each transfer; between bursts valid drops for
	// a random gap. Gaps range from a few cycles to longer than the slowest divide,
	// so they land on every phase of the calculator's work.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(20, 45);
			else
				gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// Now and then a long streaming burst, so the input side sees no idling.
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(20, 60);
			else
				burst_left = $urandom_range(0, 7);
		end
	endtask

	// Offers one key and holds it until the transfer happens. in_ready is sampled
	// right after the edge, so it still shows the value that decided the transfer.
	task automatic send_key(input logic [7:0] key);
		in_valid <= 1'b1;
		key_code <= key;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// Keys that the calculator ignores do not count toward the target.
		if ((key >= KEY_0 && key <= KEY_9) ||
				key inside {KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_EQ, KEY_CLR})
			keys_sent++;
		pace_sender();
	endtask

	// Types an unsigned value as decimal digits, most significant digit first.
	task automatic type_value(input logic [31:0] value);
		logic [7:0]  digits[$];
		logic [31:0] rest;
		logic [31:0] digit;
		rest = value;
		do begin
			digit = rest % 10;
			digits.push_front(KEY_0 + digit[7:0]);
			rest = rest / 10;
		end while (rest != 0);
		foreach (digits[i])
			send_key(digits[i]);
	endtask

	// Mostly short operands, with full-range values and the 32-bit extremes mixed in.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 99);
			4, 5: return $urandom_range(0, 99999);
			6, 7: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'd0;
					1: return 32'd1;
					2: return 32'h7FFF_FFFF;
					3: return 32'h8000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_op_key();
		case ($urandom_range(0, 3))
			0: return KEY_ADD;
			1: return KEY_SUB;
			2: return KEY_MUL;
			default: return KEY_DIV;
		endcase
	endfunction

	// Noise: either any byte at all or any meaningful key, in no particular order.
	function automatic logic [7:0] pick_noise_key();
		case ($urandom_range(0, 5))
			0, 1, 2: return 8'($urandom_range(0, 255));
			3: return KEY_0 + 8'($urandom_range(0, 9));
			4: return pick_op_key();
			default: return $urandom_range(0, 1) ? KEY_EQ : KEY_CLR;
		endcase
	endfunction

	// Result receiver. It switches between always ready, mostly ready and mostly
	// stalled on its own schedule, and once holds off for a long stretch so that the
	// output register fills, the next key finishes behind it and in_ready stays low
	// while the sender keeps offering.
	initial begin
		int cycle_no;
		int mode;
		int mode_left;
		cycle_no = 0;
		mode = 0;
		mode_left = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no == HOLD_START) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 150);
			end
			mode_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Stimulus and verdict.
	initial begin
		int choice;
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_code = 8'h00;
		keys_sent = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Equals with no operation pending gives the first operand.
		send_key(KEY_EQ);
		// Bytes with every bit low and every bit high are ignored keys.
		send_key(8'h00);
		send_key(8'hFF);
		// All ten digits in a row overflow 32 bits and wrap.
		for (int d = 9; d >= 0; d--)
			send_key(KEY_0 + d[7:0]);
		// A second operator replaces the first one; the sum then completes.
		send_key(KEY_SUB);
		send_key(KEY_ADD);
		type_value(32'd7);
		send_key(KEY_EQ);
		// Divide by zero keeps the operands and the operation but ends second entry.
		send_key(KEY_CLR);
		send_key(KEY_DIV);
		send_key(KEY_EQ);
		// The digit after that goes to the first operand. An operator does not clear
		// the second operand, so the "2" after "*" extends the 3 to 32.
		type_value(32'd8);
		send_key(KEY_DIV);
		type_value(32'd3);
		send_key(KEY_MUL);
		type_value(32'd2);
		send_key(KEY_EQ);

		// Random part, mostly complete calculations with random content.
		while (keys_sent < KEY_TARGET) begin
			choice = $urandom_range(0, 15);
			if (choice < 2) begin
				// Most negative value over minus one, one, zero or anything.
				send_key(KEY_CLR);
				type_value(32'h8000_0000);
				send_key(KEY_DIV);
				case ($urandom_range(0, 3))
					0: type_value(32'hFFFF_FFFF);
					1: type_value(32'd1);
					2: type_value(32'd0);
					default: type_value($urandom);
				endcase
				send_key(KEY_EQ);
			end else if (choice < 12) begin
				// Without a new first operand the calculation chains on the last result.
				if ($urandom_range(0, 3) != 0) begin
					if ($urandom_range(0, 2) == 0)
						send_key(KEY_CLR);
					type_value(pick_operand());
				end
				repeat ($urandom_range(1, 2)) begin
					send_key(pick_op_key());
					type_value(pick_operand());
				end
				if ($urandom_range(0, 7) != 0)
					send_key(KEY_EQ);
			end else begin
				repeat ($urandom_range(1, 6))
					send_key(pick_noise_key());
			end
		end
		in_valid <= 1'b0;

		// Let the last transfer reach the checker before looking at its count.
		@(posedge clk);
		while (keys_in_flight != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && keys_in_flight == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog, several times the slowest run that still completes correctly.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
